FILE: rtl/core/assert_macros.svh
// Assertion macros for the RTL of the frame sender.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RUN(lbl, prop, msg)
`define ASSERT_ANY(lbl, prop, msg)
`endif
`endif

FILE: rtl/core/sawfs_pkg.sv
// Package of constants and types for the stop-and-wait frame sender.
`timescale 1ns / 1ps
package sawfs_pkg;

  localparam int MAX_PAYLOAD = 256;
  localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int POS_W       = $clog2(MAX_PAYLOAD + 6);
  localparam int LEN_W       = 9;
  localparam int CMP_W       = (LEN_W > CNT_W) ? LEN_W : CNT_W;
  localparam int TRIES_W     = 4;
  localparam int CFG_W       = 9;

  localparam logic [LEN_W-1:0]   LEN_RESET   = LEN_W'(256);
  localparam logic [TRIES_W-1:0] RETRY_RESET = TRIES_W'(3);
  localparam logic [TRIES_W-1:0] TRIES_MAX   = '1;

  localparam logic [7:0] FRAME_FLAG = 8'h7E;
  localparam logic [7:0] ADDR_TX    = 8'h03;
  localparam logic [7:0] CTRL_I0    = 8'h00;
  localparam logic [7:0] CTRL_I1    = 8'h40;
  localparam logic [7:0] CTRL_RR0   = 8'h05;
  localparam logic [7:0] CTRL_RR1   = 8'h85;

  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_PULL    = 2'd1;
  localparam logic [1:0] FUNC_REPLY   = 2'd2;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd3;

  localparam logic [1:0] STATUS_NONE  = 2'd0;
  localparam logic [1:0] STATUS_ACK   = 2'd1;
  localparam logic [1:0] STATUS_RETRY = 2'd2;
  localparam logic [1:0] STATUS_FAIL  = 2'd3;

  localparam logic REG_LENGTH = 1'b0;
  localparam logic REG_RETRY  = 1'b1;

  typedef enum logic [2:0] {
    PH_LOADING = 3'b001,
    PH_SENDING = 3'b010,
    PH_WAITING = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       use_ram;
    logic       tx_valid;
    logic       frame_end;
    logic [1:0] status;
  } result_t;

endpackage

FILE: rtl/core/sawfs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module sawfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/stop_and_wait_frame_sender.sv
// Top level of the stop-and-wait frame sender.
//
//  channel | handshake               | payload
//  in      | in_valid / in_stall     | func, payload_byte, reply_control
//  out     | out_valid / out_stall   | tx_byte, tx_valid, frame_end, status
//  cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One item is taken per cycle while in_stall is low; its result passes through
// the pending stage s1 and then the output register. The payload buffer is read
// in the acceptance cycle and its data is merged as s1 moves to the output.
// Reset is synchronous and restores the empty loader, sequence bit zero,
// length 256 and retry limit 3. The buffer itself is not cleared.
// A stalled output holds one result and one more in flight before input stalls.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stop_and_wait_frame_sender
  import sawfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       func,
  input  logic [7:0]       payload_byte,
  input  logic [7:0]       reply_control,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       tx_byte,
  output logic             tx_valid,
  output logic             frame_end,
  output logic [1:0]       status,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [LEN_W-1:0]   payload_length;
  logic [TRIES_W-1:0] retry_limit;

  phase_t             phase, phase_next;
  logic [CNT_W-1:0]   load_count, load_count_next;
  logic [POS_W-1:0]   send_position, send_position_next;
  logic [7:0]         payload_check, payload_check_next;
  logic               sequence_bit, sequence_bit_next;
  logic [TRIES_W-1:0] tries_used, tries_used_next;

  logic    s1_valid;
  result_t s1, s1_next;

  logic in_accept, s1_move, out_free;

  logic              wr_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;

  logic [LEN_W-1:0] eff_length;
  logic [7:0]       ctrl_byte;
  logic [POS_W-1:0] pay_end;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_length <= LEN_RESET;
      retry_limit    <= RETRY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LENGTH: payload_length <= LEN_W'(cfg_data);
        REG_RETRY:  retry_limit    <= cfg_data[TRIES_W-1:0];
        default: ;
      endcase
    end
  end

  // Transfer control: the output register frees the pending stage.
  assign out_free  = !out_valid || !out_stall;
  assign s1_move   = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    if (payload_length == '0) begin
      eff_length = LEN_W'(1);
    end else if (CMP_W'(payload_length) > CMP_W'(MAX_PAYLOAD)) begin
      eff_length = LEN_W'(MAX_PAYLOAD);
    end else begin
      eff_length = payload_length;
    end
  end

  assign ctrl_byte = sequence_bit ? CTRL_I1 : CTRL_I0;
  assign pay_end   = POS_W'(load_count) + POS_W'(4);
  assign rd_addr   = ADDR_W'(send_position - POS_W'(4));

  always_comb begin
    phase_next         = phase;
    load_count_next    = load_count;
    send_position_next = send_position;
    payload_check_next = payload_check;
    sequence_bit_next  = sequence_bit;
    tries_used_next    = tries_used;
    wr_en              = 1'b0;
    s1_next            = '0;
    case (func)
      FUNC_LOAD: begin
        if (phase != PH_SENDING && phase != PH_WAITING) begin
          phase_next = PH_LOADING;
          if (CMP_W'(load_count) < CMP_W'(MAX_PAYLOAD)) begin
            wr_en              = 1'b1;
            payload_check_next = payload_check ^ payload_byte;
            load_count_next    = load_count + CNT_W'(1);
          end
          if (CMP_W'(load_count_next) >= CMP_W'(eff_length)) begin
            phase_next         = PH_SENDING;
            send_position_next = '0;
            tries_used_next    = '0;
          end
        end
      end
      FUNC_PULL: begin
        if (phase == PH_SENDING) begin
          s1_next.tx_valid = 1'b1;
          if (send_position == POS_W'(0)) begin
            s1_next.tx_byte = FRAME_FLAG;
          end else if (send_position == POS_W'(1)) begin
            s1_next.tx_byte = ADDR_TX;
          end else if (send_position == POS_W'(2)) begin
            s1_next.tx_byte = ctrl_byte;
          end else if (send_position == POS_W'(3)) begin
            s1_next.tx_byte = ADDR_TX ^ ctrl_byte;
          end else if (send_position < pay_end) begin
            s1_next.use_ram = 1'b1;
          end else if (send_position == pay_end) begin
            s1_next.tx_byte = payload_check;
          end else begin
            s1_next.tx_byte = FRAME_FLAG;
          end
          if (send_position >= pay_end + POS_W'(1)) begin
            s1_next.frame_end  = 1'b1;
            phase_next         = PH_WAITING;
            send_position_next = '0;
            if (tries_used != TRIES_MAX) begin
              tries_used_next = tries_used + TRIES_W'(1);
            end
          end else begin
            send_position_next = send_position + POS_W'(1);
          end
        end
      end
      default: begin
        if (phase == PH_WAITING) begin
          if (func == FUNC_REPLY
              && (reply_control == CTRL_RR0 || reply_control == CTRL_RR1)) begin
            s1_next.status     = STATUS_ACK;
            sequence_bit_next  = !sequence_bit;
            phase_next         = PH_LOADING;
            load_count_next    = '0;
            payload_check_next = '0;
            send_position_next = '0;
            tries_used_next    = '0;
          end else if (tries_used >= retry_limit) begin
            s1_next.status     = STATUS_FAIL;
            phase_next         = PH_LOADING;
            load_count_next    = '0;
            payload_check_next = '0;
            send_position_next = '0;
            tries_used_next    = '0;
          end else begin
            s1_next.status     = STATUS_RETRY;
            phase_next         = PH_SENDING;
            send_position_next = '0;
          end
        end
      end
    endcase
  end

  sawfs_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PAYLOAD)
  ) u_store (
    .clk    (clk),
    .wr_en  (in_accept && wr_en),
    .wr_addr(load_count[ADDR_W-1:0]),
    .wr_data(payload_byte),
    .rd_en  (in_accept),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LOADING;
      load_count    <= '0;
      send_position <= '0;
      payload_check <= '0;
      sequence_bit  <= 1'b0;
      tries_used    <= '0;
    end else if (in_accept) begin
      phase         <= phase_next;
      load_count    <= load_count_next;
      send_position <= send_position_next;
      payload_check <= payload_check_next;
      sequence_bit  <= sequence_bit_next;
      tries_used    <= tries_used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1 <= s1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      tx_byte   <= s1.use_ram ? rd_data : s1.tx_byte;
      tx_valid  <= s1.tx_valid;
      frame_end <= s1.frame_end;
      status    <= s1.status;
    end
  end

  `ASSERT_RUN(a_stall_needs_pending, !s1_valid |-> !in_stall, "stall with nothing pending")
  `ASSERT_RUN(a_count_bound, CMP_W'(load_count) <= CMP_W'(MAX_PAYLOAD), "count beyond buffer")
  `ASSERT_RUN(a_sending_nonempty, (phase == PH_SENDING) |-> (load_count != '0), "empty frame")
  `ASSERT_RUN(a_end_is_byte, (out_valid && frame_end) |-> tx_valid, "frame end without a byte")
  `ASSERT_ANY(a_reset_phase, rst |=> (phase == PH_LOADING && !s1_valid && !out_valid), "not reset")

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the stop-and-wait frame sender: directed table, then random traffic.
`timescale 1ns / 1ps
module tb_top;
  import sawfs_pkg::*;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       frame_end;
    logic [1:0] status;
  } tx_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic       reg_sel;
    logic [8:0] reg_val;
    logic [1:0] fn;
    logic [7:0] pbyte;
    logic [7:0] reply;
    logic       typed;
    tx_result_t want;
  } stim_row_t;

  localparam tx_result_t NO_OUTPUT = '0;
  localparam logic [7:0] CTRL_REJ0 = 8'h01;
  localparam logic [7:0] CTRL_REJ1 = 8'h81;
  localparam int DRAIN_CYCLES = 6;
  localparam int SHOWN_LIMIT = 10;
  localparam int PHASES = 8;
  localparam logic [8:0] PHASE_LEN [PHASES] =
    '{9'd3, 9'd1, 9'd0, 9'd8, 9'd256, 9'd511, 9'd5, 9'd2};
  localparam logic [8:0] PHASE_RETRY [PHASES] =
    '{9'd3, 9'd1, 9'd0, 9'd15, 9'd2, 9'd15, 9'd4, 9'd1};
  localparam int PHASE_BUDGET [PHASES] = '{200, 200, 200, 200, 600, 300, 200, 200};

  function automatic stim_row_t cfg_row(input logic sel, input logic [8:0] val);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_sel = sel;
    r.reg_val = val;
    return r;
  endfunction

  function automatic stim_row_t item_row(input logic [1:0] f, input logic [7:0] pb,
                                         input logic [7:0] rc);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.fn = f;
    r.pbyte = pb;
    r.reply = rc;
    return r;
  endfunction

  function automatic stim_row_t checked_row(input logic [1:0] f, input logic [7:0] pb,
                                            input logic [7:0] rc, input tx_result_t want);
    stim_row_t r;
    r = item_row(f, pb, rc);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic tx_result_t frame_out(input logic [7:0] b, input logic last);
    return '{b, 1'b1, last, STATUS_NONE};
  endfunction

  function automatic tx_result_t status_out(input logic [1:0] s);
    return '{8'h00, 1'b0, 1'b0, s};
  endfunction

  localparam int N_DIRECTED = 32;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    cfg_row(REG_LENGTH, 9'd0),
    cfg_row(REG_RETRY, 9'd0),
    checked_row(FUNC_PULL, 8'h00, 8'h00, NO_OUTPUT),
    checked_row(FUNC_REPLY, 8'h00, CTRL_RR0, NO_OUTPUT),
    checked_row(FUNC_LOAD, 8'hFF, 8'h00, NO_OUTPUT),
    checked_row(FUNC_LOAD, 8'h00, 8'h00, NO_OUTPUT),
    checked_row(FUNC_PULL, 8'h00, 8'h00, frame_out(FRAME_FLAG, 1'b0)),
    checked_row(FUNC_PULL, 8'h00, 8'h00, frame_out(ADDR_TX, 1'b0)),
    checked_row(FUNC_PULL, 8'h00, 8'h00, frame_out(CTRL_I0, 1'b0)),
    checked_row(FUNC_PULL, 8'h00, 8'h00, frame_out(ADDR_TX, 1'b0)),
    checked_row(FUNC_PULL, 8'h00, 8'h00, frame_out(8'hFF, 1'b0)),
    checked_row(FUNC_PULL, 8'h00, 8'h00, frame_out(8'hFF, 1'b0)),
    checked_row(FUNC_PULL, 8'h00, 8'h00, frame_out(FRAME_FLAG, 1'b1)),
    checked_row(FUNC_TIMEOUT, 8'hFF, 8'hFF, status_out(STATUS_FAIL)),
    cfg_row(REG_RETRY, 9'd15),
    checked_row(FUNC_LOAD, 8'h00, 8'h00, NO_OUTPUT),
    item_row(FUNC_PULL, 8'h00, 8'h00),
    item_row(FUNC_PULL, 8'h00, 8'h00),
    item_row(FUNC_PULL, 8'h00, 8'h00),
    item_row(FUNC_PULL, 8'h00, 8'h00),
    item_row(FUNC_PULL, 8'h00, 8'h00),
    item_row(FUNC_PULL, 8'h00, 8'h00),
    item_row(FUNC_PULL, 8'h00, 8'h00),
    checked_row(FUNC_REPLY, 8'h00, CTRL_RR1, status_out(STATUS_ACK)),
    cfg_row(REG_LENGTH, 9'd2),
    item_row(FUNC_LOAD, 8'h3C, 8'h00),
    cfg_row(REG_LENGTH, 9'd1),
    item_row(FUNC_LOAD, 8'hC3, 8'h00),
    checked_row(FUNC_REPLY, 8'h00, CTRL_RR0, NO_OUTPUT),
    item_row(FUNC_PULL, 8'h00, 8'h00),
    item_row(FUNC_PULL, 8'h00, 8'h00),
    item_row(FUNC_PULL, 8'h00, 8'h00)
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       func = FUNC_LOAD;
  logic [7:0]       payload_byte = 8'h00;
  logic [7:0]       reply_control = 8'h00;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       tx_byte;
  logic             tx_valid;
  logic             frame_end;
  logic [1:0]       status;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_index = REG_LENGTH;
  logic [CFG_W-1:0] cfg_data = '0;

  stop_and_wait_frame_sender uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .payload_byte(payload_byte), .reply_control(reply_control),
    .out_valid(out_valid), .out_stall(out_stall),
    .tx_byte(tx_byte), .tx_valid(tx_valid), .frame_end(frame_end), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [7:0]  mirror_store [MAX_PAYLOAD];
  int unsigned mirror_loaded;
  int unsigned mirror_pos;
  logic [7:0]  mirror_xor;
  logic        mirror_seq;
  logic [3:0]  mirror_tries;
  phase_t      mirror_phase;
  logic [8:0]  cur_length;
  logic [3:0]  cur_retry;

  tx_result_t expected_tx [$];
  int bad_results = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic void clear_frame();
    mirror_phase = PH_LOADING;
    mirror_loaded = 0;
    mirror_xor = 8'h00;
    mirror_pos = 0;
    mirror_tries = 4'd0;
  endfunction

  function automatic int unsigned target_length();
    if (cur_length == 0) return 1;
    if (cur_length > MAX_PAYLOAD) return MAX_PAYLOAD;
    return cur_length;
  endfunction

  function automatic tx_result_t predict_sender(input logic [1:0] f, input logic [7:0] pb,
                                                input logic [7:0] rc);
    tx_result_t r;
    logic [7:0] ctrl;
    r = NO_OUTPUT;
    ctrl = mirror_seq ? CTRL_I1 : CTRL_I0;
    case (f)
      FUNC_LOAD: begin
        if (mirror_phase == PH_LOADING) begin
          if (mirror_loaded < MAX_PAYLOAD) begin
            mirror_store[mirror_loaded] = pb;
            mirror_xor ^= pb;
            mirror_loaded++;
          end
          if (mirror_loaded >= target_length()) begin
            mirror_phase = PH_SENDING;
            mirror_pos = 0;
            mirror_tries = 4'd0;
          end
        end
      end
      FUNC_PULL: begin
        if (mirror_phase == PH_SENDING) begin
          r.tx_valid = 1'b1;
          if (mirror_pos == 0) r.tx_byte = FRAME_FLAG;
          else if (mirror_pos == 1) r.tx_byte = ADDR_TX;
          else if (mirror_pos == 2) r.tx_byte = ctrl;
          else if (mirror_pos == 3) r.tx_byte = ADDR_TX ^ ctrl;
          else if (mirror_pos < 4 + mirror_loaded) r.tx_byte = mirror_store[mirror_pos - 4];
          else if (mirror_pos == 4 + mirror_loaded) r.tx_byte = mirror_xor;
          else r.tx_byte = FRAME_FLAG;
          if (mirror_pos >= 5 + mirror_loaded) begin
            r.frame_end = 1'b1;
            mirror_phase = PH_WAITING;
            mirror_pos = 0;
            if (mirror_tries != TRIES_MAX) mirror_tries++;
          end else begin
            mirror_pos++;
          end
        end
      end
      default: begin
        if (mirror_phase == PH_WAITING) begin
          if (f == FUNC_REPLY && (rc == CTRL_RR0 || rc == CTRL_RR1)) begin
            r.status = STATUS_ACK;
            mirror_seq = ~mirror_seq;
            clear_frame();
          end else if (mirror_tries >= cur_retry) begin
            r.status = STATUS_FAIL;
            clear_frame();
          end else begin
            r.status = STATUS_RETRY;
            mirror_phase = PH_SENDING;
            mirror_pos = 0;
          end
        end
      end
    endcase
    return r;
  endfunction

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    tx_result_t got;
    tx_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {tx_byte, tx_valid, frame_end, status};
      if (expected_tx.size() == 0) begin
        if (bad_results < SHOWN_LIMIT)
          $display("Unexpected result at %0t: byte %02h valid %0b end %0b status %0d",
                   $time, got.tx_byte, got.tx_valid, got.frame_end, got.status);
        bad_results++;
      end else begin
        want = expected_tx.pop_front();
        if (got.tx_byte !== want.tx_byte || got.tx_valid !== want.tx_valid ||
            got.frame_end !== want.frame_end || got.status !== want.status) begin
          if (bad_results < SHOWN_LIMIT)
            $display("Mismatch at %0t: expected byte %02h valid %0b end %0b status %0d, got %s",
                     $time, want.tx_byte, want.tx_valid, want.frame_end, want.status,
                     $sformatf("byte %02h valid %0b end %0b status %0d",
                               got.tx_byte, got.tx_valid, got.frame_end, got.status));
          bad_results++;
        end
      end
    end
  end

  task automatic put_item(input logic [1:0] f, input logic [7:0] pb, input logic [7:0] rc,
                          input logic typed, input tx_result_t want);
    tx_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    payload_byte <= pb;
    reply_control <= rc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_sender(f, pb, rc);
    expected_tx.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_tx.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (sel == REG_LENGTH) cur_length = val;
    else cur_retry = val[3:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_traffic(input int budget);
    int done;
    int pick;
    logic paused;
    logic [7:0] answer;
    done = 0;
    paused = 1'b0;
    while (done < budget) begin
      if (!paused && done == budget / 2) begin
        wait_for_drain();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 8) begin
        put_item(2'($urandom_range(3)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 1'b0, NO_OUTPUT);
      end else begin
        case (mirror_phase)
          PH_SENDING: begin
            put_item(FUNC_PULL, 8'($urandom_range(255)), 8'($urandom_range(255)),
                     1'b0, NO_OUTPUT);
          end
          PH_WAITING: begin
            pick = $urandom_range(99);
            if (pick < 30) answer = CTRL_RR0;
            else if (pick < 60) answer = CTRL_RR1;
            else if (pick < 67) answer = CTRL_REJ0;
            else if (pick < 74) answer = CTRL_REJ1;
            else answer = 8'($urandom_range(255));
            if (pick >= 88)
              put_item(FUNC_TIMEOUT, 8'($urandom_range(255)), answer, 1'b0, NO_OUTPUT);
            else
              put_item(FUNC_REPLY, 8'($urandom_range(255)), answer, 1'b0, NO_OUTPUT);
          end
          default: begin
            put_item(FUNC_LOAD, 8'($urandom_range(255)), 8'($urandom_range(255)),
                     1'b0, NO_OUTPUT);
          end
        endcase
        done++;
      end
    end
  endtask

  initial begin
    cur_length = LEN_RESET;
    cur_retry = RETRY_RESET;
    mirror_seq = 1'b0;
    clear_frame();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        wait_for_drain();
        write_reg(DIRECTED[i].reg_sel, DIRECTED[i].reg_val);
      end else begin
        put_item(DIRECTED[i].fn, DIRECTED[i].pbyte, DIRECTED[i].reply,
                 DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_for_drain();
      write_reg(REG_LENGTH, PHASE_LEN[p]);
      if (p == 6) write_reg(REG_RETRY, 9'($urandom_range(511)));
      else write_reg(REG_RETRY, PHASE_RETRY[p]);
      case (p % 4)
        1: begin
          send_idle_pct = 61;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 61;
        end
        3: begin
          send_idle_pct = 13;
          recv_stall_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      run_traffic(PHASE_BUDGET[p]);
    end

    wait_for_drain();
    if (bad_results == 0 && expected_tx.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/sawfs_pkg.sv
rtl/core/sawfs_ram.sv
rtl/core/stop_and_wait_frame_sender.sv
tb/tb_top.sv
